@@ design/pdf_pkg.sv @@
// Shared constants and types of the perceptual deadband filter.
package pdf_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned AXES        = 3;
  localparam int unsigned FIELDS      = 3;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DB_BITS   = FRAC_BITS + 1;
  localparam logic [DB_BITS-1:0] DB_MAX   = DB_BITS'(1 << FRAC_BITS);
  localparam logic [DB_BITS-1:0] DB_RESET = DB_BITS'(6554);

  localparam int unsigned IN_W  = ((FIELDS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W = 8;

  localparam int unsigned SQ_BITS  = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_BITS = SQ_BITS + ((AXES > 1) ? $clog2(AXES) : 0);
  localparam int unsigned MA_BITS  = SUM_BITS + DB_BITS;
  localparam int unsigned MB_BITS  = (SAMPLE_BITS > DB_BITS) ? SAMPLE_BITS : DB_BITS;
  localparam int unsigned P_BITS   = MA_BITS + MB_BITS;
  localparam int unsigned LHS_BITS = SUM_BITS + 2 * FRAC_BITS;

  localparam int unsigned STEP_BUBBLE = 2 * AXES;
  localparam int unsigned STEP_RHS1   = 2 * AXES + 1;
  localparam int unsigned STEP_RHS2   = 2 * AXES + 2;
  localparam int unsigned STEP_LAST   = 2 * AXES + 3;
  localparam int unsigned STEP_BITS   = $clog2(STEP_LAST + 1);

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [STEP_BITS-1:0] step;
  } ctrl_t;

endpackage

@@ design/pdf_mul.sv @@
// Shared multiplier of the deadband filter with its registered product.
module pdf_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pdf_pkg::MA_BITS-1:0]  op_a,
  input  logic [pdf_pkg::MB_BITS-1:0]  op_b,
  output logic [pdf_pkg::P_BITS-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

@@ design/pdf_seq.sv @@
// Step sequencer that drives the shared multiplier through one decision.
module pdf_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           hold,
  output pdf_pkg::ctrl_t ctrl
);

  logic                          busy;
  logic [pdf_pkg::STEP_BITS-1:0] step;
  logic                          at_last;

  assign at_last   = (step == pdf_pkg::STEP_BITS'(pdf_pkg::STEP_LAST));
  assign ctrl.busy = busy;
  assign ctrl.done = busy && at_last;
  assign ctrl.step = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (at_last) begin
        // The last step waits here while the result word is still unclaimed.
        if (!hold) begin
          busy <= 1'b0;
        end
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

@@ design/perceptual_deadband_filter.sv @@
// Top level of the perceptual deadband filter: lanes, accumulators and result register.
//
//   channel  signals                          word contents (lowest bit first)
//   s_*      s_tvalid s_tready s_tdata[47:0]  sample_x, sample_y, sample_z
//   m_*      m_tvalid m_tready m_tdata[7:0]   transmit, then seven zero bits
//   cfg_*    cfg_valid cfg_ready cfg_data     deadband_fraction (Q1.16)
//
// One vector is handled at a time. After a word is taken on s_* the sequencer runs
// 2*AXES+4 steps (10 for three axes) through the single shared multiplier, and no new
// word is taken until it has finished and its result is in the output register.
// Reset clears the sequencer, the result valid flag and the reference-held flag and
// loads the deadband with 6554; the stored reference vector itself is not cleared.
// A stall on m_* holds the final step, and s_tready stays low until the result is
// placed in the output register.
module perceptual_deadband_filter (
  input  logic                       clk,
  input  logic                       rst,
  // sample_x [15:0], sample_y [31:16], sample_z [47:32]
  input  logic [pdf_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // transmit [0], zero padding [7:1]
  output logic [pdf_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [pdf_pkg::DB_BITS-1:0] cfg_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready
);

  localparam int unsigned SB = pdf_pkg::SAMPLE_BITS;

  pdf_pkg::ctrl_t ctrl;

  logic [pdf_pkg::DB_BITS-1:0] deadband;
  logic [pdf_pkg::DB_BITS-1:0] k_sat;
  logic                        accept;
  logic                        hold;
  logic                        have_ref;
  logic                        transmit;

  // Per-axis lanes: the incoming vector, the stored reference and their magnitudes.
  logic [SB-1:0] samp  [pdf_pkg::AXES];
  logic [SB-1:0] cur   [pdf_pkg::AXES];
  logic [SB-1:0] refv  [pdf_pkg::AXES];
  logic [SB:0]   dwide [pdf_pkg::AXES];
  logic [SB:0]   negd  [pdf_pkg::AXES];
  logic [SB:0]   negr  [pdf_pkg::AXES];
  logic [SB-1:0] absd  [pdf_pkg::AXES];
  logic [SB-1:0] absr  [pdf_pkg::AXES];
  logic [SB-1:0] adiff [pdf_pkg::AXES];
  logic [SB-1:0] aref  [pdf_pkg::AXES];

  logic [pdf_pkg::SUM_BITS-1:0] dsum;
  logic [pdf_pkg::SUM_BITS-1:0] rsum;
  logic [pdf_pkg::MA_BITS-1:0]  op_a;
  logic [pdf_pkg::MB_BITS-1:0]  op_b;
  logic [pdf_pkg::P_BITS-1:0]   prod;
  logic [pdf_pkg::LHS_BITS-1:0] lhs;
  logic                         send;

  // The deadband register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= pdf_pkg::DB_RESET;
    end else if (cfg_valid) begin
      deadband <= cfg_data;
    end
  end

  assign s_tready = !ctrl.busy;
  assign accept   = s_tvalid && s_tready;
  assign hold     = m_tvalid && !m_tready;

  // Difference and reference magnitudes are formed lane by lane as the word arrives.
  always_comb begin
    for (int i = 0; i < pdf_pkg::AXES; i++) begin
      samp[i]  = s_tdata[i*SB +: SB];
      dwide[i] = {samp[i][SB-1], samp[i]} - {refv[i][SB-1], refv[i]};
      negd[i]  = -dwide[i];
      negr[i]  = -{refv[i][SB-1], refv[i]};
      absd[i]  = dwide[i][SB] ? negd[i][SB-1:0] : dwide[i][SB-1:0];
      absr[i]  = refv[i][SB-1] ? negr[i][SB-1:0] : refv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < pdf_pkg::AXES; i++) begin
        cur[i]   <= samp[i];
        adiff[i] <= absd[i];
        aref[i]  <= absr[i];
      end
      k_sat <= (deadband > pdf_pkg::DB_MAX) ? pdf_pkg::DB_MAX : deadband;
    end
  end

  pdf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .hold  (hold),
    .ctrl  (ctrl)
  );

  // Operand selection: difference squares, then reference squares, one empty step
  // while the last square is summed, then two multiplications by k.
  always_comb begin
    op_a = '0;
    op_b = '0;
    for (int i = 0; i < pdf_pkg::AXES; i++) begin
      if (ctrl.step == pdf_pkg::STEP_BITS'(i)) begin
        op_a = pdf_pkg::MA_BITS'(adiff[i]);
        op_b = pdf_pkg::MB_BITS'(adiff[i]);
      end
      if (ctrl.step == pdf_pkg::STEP_BITS'(pdf_pkg::AXES + i)) begin
        op_a = pdf_pkg::MA_BITS'(aref[i]);
        op_b = pdf_pkg::MB_BITS'(aref[i]);
      end
    end
    if (ctrl.step == pdf_pkg::STEP_BITS'(pdf_pkg::STEP_RHS1)) begin
      op_a = pdf_pkg::MA_BITS'(rsum);
      op_b = pdf_pkg::MB_BITS'(k_sat);
    end
    if (ctrl.step == pdf_pkg::STEP_BITS'(pdf_pkg::STEP_RHS2)) begin
      op_a = prod[pdf_pkg::MA_BITS-1:0];
      op_b = pdf_pkg::MB_BITS'(k_sat);
    end
  end

  pdf_mul u_mul (
    .clk  (clk),
    .en   (ctrl.busy && !ctrl.done),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Each square is added to its sum as it leaves the registered product.
  always_ff @(posedge clk) begin
    if (accept) begin
      dsum <= '0;
      rsum <= '0;
    end else if (ctrl.busy) begin
      if (ctrl.step >= pdf_pkg::STEP_BITS'(1) &&
          ctrl.step <= pdf_pkg::STEP_BITS'(pdf_pkg::AXES)) begin
        dsum <= dsum + pdf_pkg::SUM_BITS'(prod[pdf_pkg::SQ_BITS-1:0]);
      end else if (ctrl.step >= pdf_pkg::STEP_BITS'(pdf_pkg::AXES + 1) &&
                   ctrl.step <= pdf_pkg::STEP_BITS'(pdf_pkg::STEP_BUBBLE)) begin
        rsum <= rsum + pdf_pkg::SUM_BITS'(prod[pdf_pkg::SQ_BITS-1:0]);
      end
    end
  end

  // |d|^2 scaled by 2^32 against k^2 |r|^2, both exact; the first vector always goes.
  assign lhs  = {dsum, {(2 * pdf_pkg::FRAC_BITS){1'b0}}};
  assign send = !have_ref || (pdf_pkg::P_BITS'(lhs) > prod);

  always_ff @(posedge clk) begin
    if (ctrl.done && !hold) begin
      transmit <= send;
      if (send) begin
        for (int i = 0; i < pdf_pkg::AXES; i++) begin
          refv[i] <= cur[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      have_ref <= 1'b0;
    end else begin
      if (ctrl.done && !hold) begin
        m_tvalid <= 1'b1;
        if (send) begin
          have_ref <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(pdf_pkg::OUT_W - 1)'(0), transmit};

  // A taken word always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> ctrl.busy && ctrl.step == '0)
    else $error("accepted word did not start the sequencer");

  // A finished decision with a free output register becomes a result word.
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    ctrl.done && !hold |=> m_tvalid && !ctrl.busy)
    else $error("finished decision was not presented");

  // The reference is first held only through a transmitted word.
  a_first_sends: assert property (@(posedge clk) disable iff (rst)
    $rose(have_ref) |-> m_tvalid && m_tdata[0])
    else $error("first vector after reset was not transmitted");

  // No new word while a stalled result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    hold && !ctrl.busy |=> !(m_tvalid && $changed(m_tdata)))
    else $error("stalled result changed");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the perceptual deadband filter: streams vectors, predicts every decision.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdf_pkg::*;

  // Cycles without any handshake before the run is declared hung; well above the long hold.
  localparam int IDLE_LIMIT    = 4000;
  // Leaves the block clearly idle after the last word.
  localparam int SETTLE_CYCLES = 4 * (2 * AXES + 5);
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 156;
  localparam int S_MAX         = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int S_MIN         = -(1 << (SAMPLE_BITS - 1));

  typedef logic signed [SAMPLE_BITS-1:0] axis_t;
  typedef struct {
    axis_t x;
    axis_t y;
    axis_t z;
  } vector_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  // sample_x [15:0], sample_y [31:16], sample_z [47:32]
  logic [IN_W-1:0]     s_tdata   = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  // transmit [0], zero padding [7:1]
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [DB_BITS-1:0]  cfg_data  = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;

  perceptual_deadband_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  always #5 clk = ~clk;

  // Our own copy of the filter state: the last transmitted vector and the deadband in use.
  axis_t              kept_vector [3];
  bit                 kept_valid = 1'b0;
  logic [DB_BITS-1:0] deadband   = DB_RESET;

  vector_t vector_backlog [$];
  bit      transmit_due [$];
  vector_t last_generated;

  int vectors_queued     = 0;
  int words_taken        = 0;
  int mismatches         = 0;
  int quiet_cycles       = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_asked         = 0;
  int hold_seen          = 0;
  int hold_left          = 0;
  bit s_fired            = 1'b0;

  // Decides whether a vector is sent and moves the reference along when it is.
  // The square roots are avoided: |d|^2 * 2^32 is compared against k^2 * |r|^2 exactly.
  function bit decide_transmit(input vector_t v);
    axis_t       cur [3];
    longint      d;
    longint      r;
    logic [79:0] dist_sq;
    logic [79:0] base_sq;
    logic [79:0] k;
    bit          send;
    cur[0]  = v.x;
    cur[1]  = v.y;
    cur[2]  = v.z;
    dist_sq = '0;
    base_sq = '0;
    for (int i = 0; i < AXES; i++) begin
      d       = longint'(cur[i]) - longint'(kept_vector[i]);
      r       = longint'(kept_vector[i]);
      dist_sq = dist_sq + 80'(d * d);
      base_sq = base_sq + 80'(r * r);
    end
    // Register values above 1.0 are saturated when used.
    k    = (deadband > DB_MAX) ? 80'(DB_MAX) : 80'(deadband);
    send = !kept_valid || ((dist_sq << 32) > k * k * base_sq);
    if (send) begin
      for (int i = 0; i < 3; i++) begin
        kept_vector[i] = (i < AXES) ? cur[i] : axis_t'(0);
      end
      kept_valid = 1'b1;
    end
    return send;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected transmit=%0d, got %0d", $time, what, want, got);
    end
  endtask

  // Sender: offers the next vector from the backlog, idling at random when asked to.
  always @(negedge clk) begin : drive_samples
    vector_t outgoing;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fired) begin
      if (vector_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        outgoing = vector_backlog.pop_front();
        s_tdata  <= IN_W'({outgoing.z, outgoing.y, outgoing.x});
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here whenever one is requested.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: checks each result word against the oldest prediction, predicts each accepted
  // sample word, and keeps the watchdog. Results are checked before the new prediction is
  // queued so that a word leaving and a word arriving on the same edge stay in order.
  always @(posedge clk) begin : check_results
    vector_t taken;
    bit      want;
    if (rst) begin
      s_fired      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      s_fired <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (transmit_due.size() == 0) begin
          note_mismatch("result word with nothing outstanding", -1, int'(m_tdata[0]));
        end else begin
          want = transmit_due.pop_front();
          if (m_tdata[0] !== want) begin
            note_mismatch("wrong decision", int'(want), int'(m_tdata[0]));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        taken.x = s_tdata[0 +: SAMPLE_BITS];
        taken.y = s_tdata[SAMPLE_BITS +: SAMPLE_BITS];
        taken.z = s_tdata[2 * SAMPLE_BITS +: SAMPLE_BITS];
        transmit_due.push_back(decide_transmit(taken));
        words_taken++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_vector(input int x, input int y, input int z);
    vector_t v;
    v.x = axis_t'(x);
    v.y = axis_t'(y);
    v.z = axis_t'(z);
    vector_backlog.push_back(v);
    last_generated = v;
    vectors_queued++;
  endtask

  // The stimulus holds back here until every word has been taken and every result has come.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (words_taken != vectors_queued || transmit_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle; the predictor follows once the write has been taken.
  task automatic write_deadband(input logic [DB_BITS-1:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    deadband = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int nudge(input axis_t a);
    int span;
    int v;
    span = 1 << $urandom_range(14);
    v    = int'(a) + int'($urandom_range(2 * span)) - span;
    if (v > S_MAX) v = S_MAX;
    if (v < S_MIN) v = S_MIN;
    return v;
  endfunction

  // Mostly small moves around the previous vector, so both decisions stay frequent, with
  // some repeats, some zero vectors and some fully random words for bit coverage.
  task automatic queue_random_vector();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      queue_vector(int'(axis_t'($urandom)), int'(axis_t'($urandom)), int'(axis_t'($urandom)));
    end else if (pick < 22) begin
      queue_vector(last_generated.x, last_generated.y, last_generated.z);
    end else if (pick < 25) begin
      queue_vector(0, 0, 0);
    end else begin
      queue_vector(nudge(last_generated.x), nudge(last_generated.y), nudge(last_generated.z));
    end
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct    = 82;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 82;
      end
      default: begin
        sender_idle_pct    = 33;
        receiver_stall_pct = 33;
      end
    endcase
  endtask

  initial begin : stimulus
    logic [DB_BITS-1:0] phase_deadband [8];
    last_generated = '{x: '0, y: '0, z: '0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, first at the reset deadband of about 0.1.
    set_idling(IDLE_NONE);
    queue_vector(0, 0, 0);                  // first vector after reset is always sent
    queue_vector(0, 0, 0);                  // zero reference, zero difference: suppressed
    queue_vector(1, 0, 0);                  // zero reference, any difference is sent
    queue_vector(S_MIN, S_MIN, S_MIN);
    queue_vector(S_MAX, S_MAX, S_MAX);
    queue_vector(S_MAX, S_MAX, S_MAX - 1);  // tiny move on a long reference
    queue_vector(S_MIN, S_MAX, S_MIN);
    queue_vector(-21846, 21845, 3855);
    wait_drained();

    // Zero deadband: an identical vector is suppressed, any change is sent.
    write_deadband('0);
    queue_vector(-21846, 21845, 3855);
    queue_vector(-21845, 21845, 3855);
    queue_vector(-21845, 21845, 3855);
    wait_drained();

    // A deadband of exactly one: a difference as long as the reference is not enough.
    write_deadband(DB_MAX);
    queue_vector(0, 0, 0);
    queue_vector(S_MAX, -S_MAX, S_MAX);
    queue_vector(S_MIN, S_MAX, S_MIN);
    wait_drained();

    // Register values above one behave as one.
    write_deadband('1);
    queue_vector(0, 0, 1);
    queue_vector(S_MIN, S_MIN, S_MIN);
    queue_vector(0, 0, 0);
    wait_drained();
    write_deadband(DB_MAX + DB_BITS'(1));
    queue_vector(S_MAX, S_MAX, S_MAX);
    queue_vector(1, 1, 1);
    queue_vector(S_MIN, 0, S_MAX);
    wait_drained();

    phase_deadband[0] = DB_RESET;
    phase_deadband[1] = '0;
    phase_deadband[2] = DB_MAX;
    phase_deadband[3] = '1;
    phase_deadband[4] = DB_BITS'($urandom_range(131071));
    phase_deadband[5] = DB_BITS'($urandom_range(8000));
    phase_deadband[6] = DB_BITS'(65537 + $urandom_range(65534));
    phase_deadband[7] = DB_BITS'(3277);

    for (int phase = 0; phase < 8; phase++) begin
      write_deadband(phase_deadband[phase]);
      set_idling(idle_mode_t'(phase % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_random_vector();
      end
      // In the first phase the receiver holds off for a long stretch while the sender
      // keeps offering, so the block backs up and stalls its input.
      if (phase == 0) begin
        hold_asked++;
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
